[hw/rtl/assert_macros.svh]
// Assertion helpers, clocked on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/srsd_pkg.sv]
package srsd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned COL_W    = 3;
    localparam int unsigned CCOUNT_W = 4;
    localparam int unsigned BCNT_W   = 3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_INT,
        PH_TLEN,
        PH_TEXT,
        PH_DONE,
        PH_DROP
    } phase_t;

    localparam logic [1:0] KIND_INT    = 2'd0;
    localparam logic [1:0] KIND_TLEN   = 2'd1;
    localparam logic [1:0] KIND_TEXT   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CORRUPT = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [1:0] REG_COL_TOTAL    = 2'd0;
    localparam logic [1:0] REG_TEXT_COLUMNS = 2'd1;
    localparam logic [1:0] REG_MAX_LEN_LOW  = 2'd2;
    localparam logic [1:0] REG_MAX_LEN_HIGH = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              final_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic [COL_W-1:0]         column;
        logic signed [WORD_W-1:0] value;
        logic                     record_end;
        logic [1:0]               status;
    } out_item_t;

    typedef struct packed {
        logic [CCOUNT_W-1:0] col_total;
        logic [7:0]          text_columns;
        logic [WORD_W-1:0]   max_len_low;
        logic [WORD_W-1:0]   max_len_high;
    } cfg_t;

endpackage

[hw/rtl/srsd_fifo.sv]
module srsd_fifo #(
    parameter int unsigned DEPTH = 2,
    parameter type data_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  data_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output data_t rd_data,
    output logic  empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    data_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hw/rtl/srsd_decode.sv]
module srsd_decode #(
    parameter int unsigned MAX_COLUMNS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  srsd_pkg::cfg_t     cfg,
    input  logic               in_valid,
    input  srsd_pkg::in_item_t in_data,
    output logic               in_take,
    input  logic               out_full,
    output logic               out_push,
    output srsd_pkg::out_item_t out_data
);

    import srsd_pkg::*;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [BCNT_W-1:0]   byte_reg;
    logic [BCNT_W-1:0]   byte_next;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [WORD_W-1:0]   word_reg;
    logic [WORD_W-1:0]   word_next;
    logic [LEN_W-1:0]    rem_reg;
    logic [LEN_W-1:0]    rem_next;

    logic                step;
    logic                fin;
    logic [BYTE_W-1:0]   b;
    logic [WORD_W-1:0]   word_lane;
    logic [WORD_W-1:0]   limit_word;
    logic [LEN_W-1:0]    limit;
    logic                bad_count;
    logic                do_fail;
    logic [1:0]          fail_status;
    logic                do_finish;
    logic [1:0]          fin_kind;
    logic [WORD_W-1:0]   fin_value;
    logic [CCOUNT_W-1:0] next_col;
    logic                complete;

    assign step     = in_valid && !out_full;
    assign in_take  = step;
    assign fin      = in_data.final_byte;
    assign b        = in_data.in_byte;

    assign limit_word = col_reg[2] ? cfg.max_len_high : cfg.max_len_low;
    assign limit      = limit_word[{col_reg[1:0], 4'b0000} +: LEN_W];
    assign bad_count  = (cfg.col_total == '0)
                     || (32'(cfg.col_total) > 32'(MAX_COLUMNS));
    assign next_col   = {1'b0, col_reg} + CCOUNT_W'(1);
    assign complete   = (next_col >= cfg.col_total);

    always_comb
    begin
        word_lane = word_reg;
        word_lane[{byte_reg, 3'b000} +: BYTE_W] = b;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        byte_next   = byte_reg;
        col_next    = col_reg;
        word_next   = word_reg;
        rem_next    = rem_reg;
        do_fail     = 1'b0;
        fail_status = ST_CORRUPT;
        do_finish   = 1'b0;
        fin_kind    = KIND_INT;
        fin_value   = '0;
        out_push    = 1'b0;
        out_data    = '0;

        if (step)
        begin
            if (phase_reg == PH_DROP)
            begin
                if (fin)
                begin
                    phase_next = PH_HEADER;
                    byte_next  = '0;
                    col_next   = '0;
                    word_next  = '0;
                    rem_next   = '0;
                end
            end
            else if (bad_count)
            begin
                do_fail     = 1'b1;
                fail_status = ST_INVALID;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        word_next = word_lane;
                        if (byte_reg >= BCNT_W'(3))
                        begin
                            if ((word_lane[31:0] != {28'b0, cfg.col_total}) || fin)
                            begin
                                do_fail = 1'b1;
                            end
                            else
                            begin
                                col_next   = '0;
                                phase_next = cfg.text_columns[0] ? PH_TLEN : PH_INT;
                                byte_next  = '0;
                                word_next  = '0;
                            end
                        end
                        else
                        begin
                            byte_next = byte_reg + 1'b1;
                            do_fail   = fin;
                        end
                    end
                    PH_INT:
                    begin
                        word_next = word_lane;
                        if (byte_reg == BCNT_W'(7))
                        begin
                            do_finish = 1'b1;
                            fin_kind  = KIND_INT;
                            fin_value = word_lane;
                        end
                        else
                        begin
                            byte_next = byte_reg + 1'b1;
                            do_fail   = fin;
                        end
                    end
                    PH_TLEN:
                    begin
                        word_next = word_lane;
                        if (byte_reg < BCNT_W'(3))
                        begin
                            byte_next = byte_reg + 1'b1;
                            do_fail   = fin;
                        end
                        else if (word_lane[31:0] > {16'b0, limit})
                        begin
                            do_fail     = 1'b1;
                            fail_status = ST_INVALID;
                        end
                        else if (word_lane[31:0] == '0)
                        begin
                            do_finish = 1'b1;
                            fin_kind  = KIND_TLEN;
                            fin_value = '0;
                        end
                        else if (fin)
                        begin
                            do_fail = 1'b1;
                        end
                        else
                        begin
                            rem_next            = word_lane[LEN_W-1:0];
                            phase_next          = PH_TEXT;
                            out_push            = 1'b1;
                            out_data.kind       = KIND_TLEN;
                            out_data.column     = col_reg;
                            out_data.value      = {32'b0, word_lane[31:0]};
                            out_data.record_end = 1'b0;
                            out_data.status     = ST_OK;
                        end
                    end
                    PH_TEXT:
                    begin
                        if (rem_reg <= LEN_W'(1))
                        begin
                            rem_next  = '0;
                            do_finish = 1'b1;
                            fin_kind  = KIND_TEXT;
                            fin_value = {56'b0, b};
                        end
                        else
                        begin
                            rem_next = rem_reg - 1'b1;
                            if (fin)
                            begin
                                do_fail = 1'b1;
                            end
                            else
                            begin
                                out_push            = 1'b1;
                                out_data.kind       = KIND_TEXT;
                                out_data.column     = col_reg;
                                out_data.value      = {56'b0, b};
                                out_data.record_end = 1'b0;
                                out_data.status     = ST_OK;
                            end
                        end
                    end
                    default:
                    begin
                        do_fail = 1'b1;
                    end
                endcase
            end

            if (do_finish)
            begin
                if (fin && !complete)
                begin
                    do_fail     = 1'b1;
                    fail_status = ST_CORRUPT;
                end
                else
                begin
                    out_push            = 1'b1;
                    out_data.kind       = fin_kind;
                    out_data.column     = col_reg;
                    out_data.value      = fin_value;
                    out_data.record_end = complete && fin;
                    out_data.status     = ST_OK;
                    if (complete)
                    begin
                        if (fin)
                        begin
                            phase_next = PH_HEADER;
                            byte_next  = '0;
                            col_next   = '0;
                            word_next  = '0;
                            rem_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    else
                    begin
                        col_next   = next_col[COL_W-1:0];
                        phase_next = cfg.text_columns[next_col[COL_W-1:0]] ? PH_TLEN : PH_INT;
                        byte_next  = '0;
                        word_next  = '0;
                    end
                end
            end

            if (do_fail)
            begin
                out_push            = 1'b1;
                out_data.kind       = KIND_STATUS;
                out_data.column     = col_reg;
                out_data.value      = '0;
                out_data.record_end = 1'b1;
                out_data.status     = fail_status;
                if (fin)
                begin
                    phase_next = PH_HEADER;
                    byte_next  = '0;
                    col_next   = '0;
                    word_next  = '0;
                    rem_next   = '0;
                end
                else
                begin
                    phase_next = PH_DROP;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            byte_reg  <= '0;
            col_reg   <= '0;
            word_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            byte_reg  <= byte_next;
            col_reg   <= col_next;
            word_reg  <= word_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

[hw/rtl/schema_record_stream_decoder.sv]
// Length-prefixed record decoder, one encoded byte per item.
// Input side is a queue: write an item with push while full is low; final_byte
// marks the last byte of the encoded buffer.
// Result side is a queue: while empty is low the oldest result sits on result;
// pop takes it. Header bytes and most length bytes give no result.
// Schema registers are written through cfg_write/cfg_index/cfg_data (index 0
// column count, 1 text column mask, 2 and 3 the packed 16-bit text length
// limits); the user must write them only while no record is in flight, which
// the block itself does not enforce. Throughput: one byte per cycle while the
// output queue is not full. A byte is registered in the input queue, decoded
// combinationally, and its result is registered in the output queue, where pop
// can take it.
// When pop stays low the 2-entry output queue fills, decoding halts and the
// 2-entry input queue fills, so full rises; nothing is dropped.
// Reset clears both queues and the decoder, and sets the schema to one
// integer column with all text limits at zero.
`include "assert_macros.svh"

module schema_record_stream_decoder #(
    parameter int unsigned MAX_COLUMNS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  srsd_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output srsd_pkg::out_item_t result,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data
);

    import srsd_pkg::*;

    cfg_t      cfg_reg;
    logic      in_empty;
    logic      in_take;
    in_item_t  in_head;
    logic      out_full;
    logic      out_push;
    out_item_t out_data;
    logic      err_head;
    logic      err_closed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.col_total    <= CCOUNT_W'(1);
            cfg_reg.text_columns <= '0;
            cfg_reg.max_len_low  <= '0;
            cfg_reg.max_len_high <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_COL_TOTAL:    cfg_reg.col_total    <= cfg_data[CCOUNT_W-1:0];
                REG_TEXT_COLUMNS: cfg_reg.text_columns <= cfg_data[7:0];
                REG_MAX_LEN_LOW:  cfg_reg.max_len_low  <= cfg_data;
                REG_MAX_LEN_HIGH: cfg_reg.max_len_high <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    srsd_fifo #(
        .DEPTH  (2),
        .data_t (in_item_t)
    ) u_in_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (item),
        .full    (full),
        .rd_en   (in_take),
        .rd_data (in_head),
        .empty   (in_empty)
    );

    srsd_decode #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (!in_empty),
        .in_data  (in_head),
        .in_take  (in_take),
        .out_full (out_full),
        .out_push (out_push),
        .out_data (out_data)
    );

    srsd_fifo #(
        .DEPTH  (2),
        .data_t (out_item_t)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_data),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

    assign err_head   = !empty && (result.status != ST_OK);
    assign err_closed = (result.kind == KIND_STATUS) && result.record_end;

    `ASSERT_NEVER(a_out_overflow, out_push && out_full, "result pushed into full queue")
    `ASSERT_NEVER(a_take_empty, in_take && in_empty, "decoder took from empty queue")
    `ASSERT_CLK(a_error_shape, err_head |-> err_closed, "error result not closing record")

endmodule

[test/schema_record_stream_decoder_test.sv]
`timescale 1ns / 100ps

module schema_record_stream_decoder_test;
    import srsd_pkg::*;

    localparam int MAX_COLUMNS    = 8;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int SCRIPT_LEN     = 29;

    typedef enum logic [0:0] {ROW_BYTE, ROW_REG} row_op_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} row_chk_t;
    typedef enum int {FLAW_NONE, FLAW_COUNT, FLAW_TRUNC, FLAW_TRAIL, FLAW_LONG, FLAW_NOISE} flaw_t;

    typedef struct packed {
        row_op_t     op;
        logic [1:0]  reg_idx;
        logic [63:0] reg_data;
        logic [7:0]  in_byte;
        logic        final_byte;
        row_chk_t    chk;
        out_item_t   want;
    } script_row_t;

    localparam out_item_t R_NONE = '0;
    localparam out_item_t R_CORRUPT = '{kind: KIND_STATUS, column: 3'd0, value: 64'sd0,
                                        record_end: 1'b1, status: ST_CORRUPT};
    localparam out_item_t R_INVALID = '{kind: KIND_STATUS, column: 3'd0, value: 64'sd0,
                                        record_end: 1'b1, status: ST_INVALID};
    localparam out_item_t R_EMPTY_TEXT = '{kind: KIND_TLEN, column: 3'd0, value: 64'sd0,
                                           record_end: 1'b0, status: ST_OK};

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // header cut short straight after reset
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'hFF, 1'b1, CHK_TYPED, R_CORRUPT},
        '{ROW_REG, REG_COL_TOTAL, 64'd1, 8'h00, 1'b0, CHK_NONE, R_NONE},
        '{ROW_REG, REG_TEXT_COLUMNS, 64'h01, 8'h00, 1'b0, CHK_NONE, R_NONE},
        '{ROW_REG, REG_MAX_LEN_LOW, 64'h2, 8'h00, 1'b0, CHK_NONE, R_NONE},
        '{ROW_REG, REG_MAX_LEN_HIGH, '1, 8'h00, 1'b0, CHK_NONE, R_NONE},
        // empty text, then a trailing byte
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h01, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b0, CHK_TYPED, R_EMPTY_TEXT},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b1, CHK_TYPED, R_CORRUPT},
        // wrong column count, then drop up to the final byte
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'hFF, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'hFF, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'hFF, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'hFF, 1'b0, CHK_TYPED, R_CORRUPT},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h5A, 1'b1, CHK_MODEL, R_NONE},
        // text over its limit wins over truncation
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h01, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h03, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b0, CHK_MODEL, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h00, 1'b1, CHK_TYPED, R_INVALID},
        // schema count out of range
        '{ROW_REG, REG_COL_TOTAL, 64'd9, 8'h00, 1'b0, CHK_NONE, R_NONE},
        '{ROW_BYTE, REG_COL_TOTAL, 64'd0, 8'h80, 1'b1, CHK_TYPED, R_INVALID}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    item = '0;
    logic        empty;
    logic        pop = 1'b0;
    out_item_t   result;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // decoder image
    phase_t      dec_phase;
    logic [2:0]  dec_byte_no;
    logic [3:0]  dec_col;
    logic [63:0] dec_word;
    logic [31:0] dec_text_left;
    logic [3:0]  sch_count;
    logic [7:0]  sch_text;
    logic [63:0] sch_lim_lo;
    logic [63:0] sch_lim_hi;

    out_item_t   column_reports [$];
    in_item_t    record_bytes [$];
    int          errors = 0;
    int          quiet = 0;
    int          pop_hold = 0;
    int          burst_left = 0;
    bit          steady = 1'b0;

    schema_record_stream_decoder #(.MAX_COLUMNS(MAX_COLUMNS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void restart_record();
        dec_phase     = PH_HEADER;
        dec_byte_no   = '0;
        dec_col       = '0;
        dec_word      = '0;
        dec_text_left = '0;
    endfunction

    function automatic void open_column();
        dec_phase   = sch_text[dec_col[2:0]] ? PH_TLEN : PH_INT;
        dec_byte_no = '0;
        dec_word    = '0;
    endfunction

    function automatic logic [15:0] lane_limit(input int unsigned c);
        logic [63:0] w;
        w = (c % 8 < 4) ? sch_lim_lo : sch_lim_hi;
        return w[16 * (c % 4) +: 16];
    endfunction

    function automatic out_item_t make_report(input logic [1:0] k, input logic [63:0] v,
                                              input bit e, input logic [1:0] st);
        out_item_t r;
        r.kind       = k;
        r.column     = dec_col[2:0];
        r.value      = v;
        r.record_end = e;
        r.status     = st;
        return r;
    endfunction

    function automatic bit abort_record(input logic [1:0] st, input bit fin,
                                        output out_item_t r);
        r = make_report(KIND_STATUS, 64'd0, 1'b1, st);
        if (fin)
            restart_record();
        else
            dec_phase = PH_DROP;
        return 1'b1;
    endfunction

    function automatic bit close_column(input logic [1:0] k, input logic [63:0] v,
                                        input bit fin, output out_item_t r);
        logic [4:0] nxt;
        bit         complete;
        nxt = {1'b0, dec_col} + 5'd1;
        complete = (nxt >= {1'b0, sch_count});
        if (fin && !complete)
            return abort_record(ST_CORRUPT, fin, r);
        r = make_report(k, v, complete && fin, ST_OK);
        if (complete)
        begin
            if (fin)
                restart_record();
            else
                dec_phase = PH_DONE;
        end
        else
        begin
            dec_col = nxt[3:0];
            open_column();
        end
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input in_item_t it, output out_item_t r);
        logic [63:0] b;
        bit          fin;
        logic [31:0] len;
        b   = 64'(it.in_byte);
        fin = it.final_byte;
        r   = '0;
        if (dec_phase == PH_DROP)
        begin
            if (fin)
                restart_record();
            return 1'b0;
        end
        if (sch_count == 0 || sch_count > MAX_COLUMNS)
            return abort_record(ST_INVALID, fin, r);
        case (dec_phase)
            PH_HEADER:
            begin
                dec_word = dec_word | (b << (8 * dec_byte_no));
                if (dec_byte_no >= 3)
                begin
                    if (dec_word[31:0] != 32'(sch_count) || fin)
                        return abort_record(ST_CORRUPT, fin, r);
                    dec_col = '0;
                    open_column();
                    return 1'b0;
                end
                dec_byte_no++;
                return fin ? abort_record(ST_CORRUPT, fin, r) : 1'b0;
            end
            PH_INT:
            begin
                dec_word = dec_word | (b << (8 * dec_byte_no));
                if (dec_byte_no >= 7)
                    return close_column(KIND_INT, dec_word, fin, r);
                dec_byte_no++;
                return fin ? abort_record(ST_CORRUPT, fin, r) : 1'b0;
            end
            PH_TLEN:
            begin
                dec_word = dec_word | (b << (8 * dec_byte_no));
                if (dec_byte_no < 3)
                begin
                    dec_byte_no++;
                    return fin ? abort_record(ST_CORRUPT, fin, r) : 1'b0;
                end
                len = dec_word[31:0];
                if (len > {16'd0, lane_limit(dec_col)})
                    return abort_record(ST_INVALID, fin, r);
                if (len == 0)
                    return close_column(KIND_TLEN, 64'd0, fin, r);
                if (fin)
                    return abort_record(ST_CORRUPT, fin, r);
                dec_text_left = len;
                dec_phase = PH_TEXT;
                r = make_report(KIND_TLEN, 64'(len), 1'b0, ST_OK);
                return 1'b1;
            end
            PH_TEXT:
            begin
                if (dec_text_left <= 1)
                begin
                    dec_text_left = '0;
                    return close_column(KIND_TEXT, b, fin, r);
                end
                dec_text_left--;
                if (fin)
                    return abort_record(ST_CORRUPT, fin, r);
                r = make_report(KIND_TEXT, b, 1'b0, ST_OK);
                return 1'b1;
            end
            default:
                return abort_record(ST_CORRUPT, fin, r);
        endcase
    endfunction

    function automatic void field_diff(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result(input out_item_t got);
        out_item_t want;
        if (column_reports.size() == 0)
        begin
            $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = column_reports.pop_front();
        field_diff("kind", 64'(want.kind), 64'(got.kind));
        field_diff("column", 64'(want.column), 64'(got.column));
        field_diff("value", want.value, got.value);
        field_diff("record_end", 64'(want.record_end), 64'(got.record_end));
        field_diff("status", 64'(want.status), 64'(got.status));
    endfunction

    function automatic void add_le(input logic [63:0] w, input int n);
        for (int i = 0; i < n; i++)
            record_bytes.push_back('{in_byte: w[8 * i +: 8], final_byte: 1'b0});
    endfunction

    function automatic logic [63:0] pick_int();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return 64'h8000_0000_0000_0000;
            2: return 64'h7FFF_FFFF_FFFF_FFFF;
            3: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic flaw_t pick_flaw();
        case ($urandom_range(0, 9))
            6: return FLAW_TRUNC;
            7: return FLAW_TRAIL;
            8: return FLAW_LONG;
            9: return $urandom_range(0, 1) ? FLAW_COUNT : FLAW_NOISE;
            default: return FLAW_NONE;
        endcase
    endfunction

    function automatic void build_record(input flaw_t flaw);
        int unsigned ncol;
        int unsigned long_col;
        int unsigned lim;
        int unsigned len;
        int unsigned cut;
        record_bytes.delete();
        if (flaw == FLAW_NOISE)
        begin
            repeat ($urandom_range(1, 8))
                record_bytes.push_back('{in_byte: 8'($urandom),
                                         final_byte: ($urandom_range(0, 3) == 0)});
        end
        else
        begin
            ncol = (sch_count >= 1 && sch_count <= MAX_COLUMNS) ? sch_count
                                                                : $urandom_range(1, MAX_COLUMNS);
            long_col = $urandom_range(0, ncol - 1);
            if (flaw == FLAW_COUNT)
                add_le($urandom_range(0, 1) ? 64'($urandom) : 64'(sch_count) + 1, 4);
            else
                add_le(64'(sch_count), 4);
            for (int c = 0; c < ncol; c++)
            begin
                if (sch_text[c])
                begin
                    lim = lane_limit(c);
                    if (flaw == FLAW_LONG && c == long_col)
                    begin
                        len = (lim == 16'hFFFF || $urandom_range(0, 1)) ? ($urandom | 32'h10000)
                                                                      : lim + $urandom_range(1, 3);
                        add_le(64'(len), 4);
                        repeat ($urandom_range(0, 3))
                            add_le(64'($urandom), 1);
                        break;
                    end
                    len = $urandom_range(0, (lim < 6) ? lim : 6);
                    if (lim <= 40 && $urandom_range(0, 3) == 0)
                        len = lim;
                    add_le(64'(len), 4);
                    repeat (len)
                        add_le(64'($urandom), 1);
                end
                else
                    add_le(pick_int(), 8);
            end
            if (flaw == FLAW_TRUNC && record_bytes.size() > 1)
            begin
                cut = $urandom_range(1, record_bytes.size() - 1);
                while (record_bytes.size() > cut)
                    void'(record_bytes.pop_back());
            end
            if (flaw == FLAW_TRAIL)
                repeat ($urandom_range(1, 3))
                    add_le(64'($urandom), 1);
        end
        record_bytes[record_bytes.size() - 1].final_byte = 1'b1;
    endfunction

    task automatic send_item(input in_item_t it, input row_chk_t chk, input out_item_t want);
        out_item_t got;
        bit        produced;
        if (!steady && burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0)
            burst_left--;
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        produced = decode_byte(it, got);
        if (chk == CHK_MODEL && produced)
            column_reports.push_back(got);
        else if (chk == CHK_TYPED)
            column_reports.push_back(want);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (column_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_COL_TOTAL:    sch_count  = data[3:0];
            REG_TEXT_COLUMNS: sch_text   = data[7:0];
            REG_MAX_LEN_LOW:  sch_lim_lo = data;
            REG_MAX_LEN_HIGH: sch_lim_hi = data;
            default: ;
        endcase
    endtask

    task automatic pick_schema(input int phase_no);
        logic [3:0]  cnt;
        logic [7:0]  txt;
        logic [63:0] lo;
        logic [63:0] hi;
        case (phase_no)
            0:
            begin
                cnt = 4'd8; txt = 8'hFF; lo = '1; hi = '1;
            end
            1:
            begin
                cnt = 4'd1; txt = 8'h00; lo = '0; hi = '0;
            end
            2:
            begin
                cnt = 4'd8; txt = 8'h00; lo = '1; hi = '0;
            end
            3:
            begin
                cnt = 4'd1; txt = 8'hFF; lo = '0; hi = '0;
            end
            default:
            begin
                if ($urandom_range(0, 11) == 0)
                    cnt = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
                else
                    cnt = 4'($urandom_range(1, MAX_COLUMNS));
                txt = 8'($urandom);
                for (int l = 0; l < 4; l++)
                begin
                    lo[16 * l +: 16] = pick_limit();
                    hi[16 * l +: 16] = pick_limit();
                end
            end
        endcase
        write_reg(REG_COL_TOTAL, 64'(cnt));
        write_reg(REG_TEXT_COLUMNS, 64'(txt));
        write_reg(REG_MAX_LEN_LOW, lo);
        write_reg(REG_MAX_LEN_HIGH, hi);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            pop_hold <= 0;
        end
        else
        begin
            if (pop && !empty)
                check_result(result);
            if (pop_hold > 0)
                pop_hold <= pop_hold - 1;
            else if (pop)
            begin
                pop      <= 1'b0;
                pop_hold <= $urandom_range(1, 14);
            end
            else
            begin
                pop      <= 1'b1;
                pop_hold <= ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(0, 24);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet <= 0;
            else if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("schema_record_stream_decoder_test: done, errors");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        int fed;
        int phase_no;
        in_item_t it;
        sch_count  = 4'd1;
        sch_text   = '0;
        sch_lim_lo = '0;
        sch_lim_hi = '0;
        restart_record();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (SCRIPT[i].op == ROW_REG)
            begin
                settle();
                write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_data);
            end
            else
            begin
                it.in_byte    = SCRIPT[i].in_byte;
                it.final_byte = SCRIPT[i].final_byte;
                send_item(it, SCRIPT[i].chk, SCRIPT[i].want);
            end
        end

        fed = 0;
        phase_no = 0;
        while (fed < RANDOM_ITEMS)
        begin
            settle();
            pick_schema(phase_no);
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 4))
            begin
                build_record(pick_flaw());
                fed += record_bytes.size();
                for (int i = 0; i < record_bytes.size(); i++)
                    send_item(record_bytes[i], CHK_MODEL, R_NONE);
            end
            phase_no++;
        end

        settle();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("schema_record_stream_decoder_test: done, clean");
        else
            $display("schema_record_stream_decoder_test: done, errors");
        $finish;
    end

endmodule
